// ----- rtl/lmks_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmks_pkg
// shared widths, request and register codes and the decoded request struct
// for the led matrix and keypad scanner
// ----------------------------------------------------------------------------
package lmks_pkg;

  localparam int unsigned REQ_W      = 3;
  localparam int unsigned ROW_W      = 4;
  localparam int unsigned COL_W      = 3;
  localparam int unsigned BTN_W      = 3;
  localparam int unsigned KEY_BITS   = 6;
  localparam int unsigned DRIVE_W    = 16;
  localparam int unsigned LEVEL_W    = 3;
  localparam int unsigned TS_W       = 16;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CNT_W-1:0]   CNT_MAX         = 8'hFF;
  localparam logic [TS_W-1:0]    FIRST_DELAY_RST = 16'd200;
  localparam logic [TS_W-1:0]    REARM_RST       = 16'd150;
  localparam logic [LEVEL_W-1:0] HOLD_LIMIT_RST  = 3'd5;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK      = 3'd0,
    REQ_WRITE_PIX = 3'd1,
    REQ_READ_PIX  = 3'd2,
    REQ_POP_EVENT = 3'd3,
    REQ_READ_HOLD = 3'd4
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_DELAY = 2'd0,
    CFG_REARM_BACK  = 2'd1,
    CFG_HOLD_LIMIT  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic tick;
    logic wr_pix;
    logic rd_pix;
    logic pop;
    logic rd_hold;
  } req_dec_t;

endpackage
`default_nettype wire

// ----- rtl/led_matrix_and_keypad_scanner.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// led_matrix_and_keypad_scanner
// column-scanned led frame store with keypad sampling and auto-repeat
// ----------------------------------------------------------------------------
// Takes one request per clock while the result side is not stalled and returns
// one result per request: the request is first captured in an input register,
// then applied to the frame store and key state as the result register is
// loaded. Both registers are always free to move while the result side is
// not stalled, so a new request can follow every cycle. The
// frame store is cleared by reset directly; no start-up pass is needed.
// Configuration writes go through the write port at any time the block is idle.
// ----------------------------------------------------------------------------
module led_matrix_and_keypad_scanner #(
  parameter int unsigned ROWS = 16,
  parameter int unsigned COLS = 8,
  parameter int unsigned KEYS = 6
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire  [lmks_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire  [lmks_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire  [lmks_pkg::REQ_W-1:0]          req_type_i,
  input  wire  [lmks_pkg::ROW_W-1:0]          row_i,
  input  wire  [lmks_pkg::COL_W-1:0]          column_i,
  input  wire                                 pixel_in_i,
  input  wire  [lmks_pkg::BTN_W-1:0]          button_i,
  input  wire  [lmks_pkg::KEY_BITS-1:0]       keys_pressed_i,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic [lmks_pkg::DRIVE_W-1:0]        row_drive_o,
  output logic [lmks_pkg::COL_W-1:0]          active_column_o,
  output logic                                pixel_out_o,
  output logic                                event_taken_o,
  output logic [lmks_pkg::LEVEL_W-1:0]        hold_level_o
);

  localparam int unsigned CW = (COLS > 1) ? $clog2(COLS) : 1;

  // configuration
  logic [lmks_pkg::TS_W-1:0]    first_delay_q;
  logic [lmks_pkg::TS_W-1:0]    rearm_q;
  logic [lmks_pkg::LEVEL_W-1:0] hold_limit_q;

  // input register
  logic                          in_valid_q;
  lmks_pkg::req_e                req_q;
  logic [lmks_pkg::ROW_W-1:0]    row_q;
  logic [lmks_pkg::COL_W-1:0]    col_q;
  logic                          pix_q;
  logic [lmks_pkg::BTN_W-1:0]    btn_q;
  logic [lmks_pkg::KEY_BITS-1:0] keys_q;

  // scan state
  logic [CW-1:0]             scan_q, scan_d;
  logic [lmks_pkg::TS_W-1:0] tick_q, tick_d;

  logic                         out_busy;
  logic                         advance;
  lmks_pkg::req_dec_t           dec;
  logic                         pix_rd;
  logic                         taken;
  logic [lmks_pkg::LEVEL_W-1:0] level;
  logic [lmks_pkg::DRIVE_W-1:0] drive;

  assign out_busy   = out_valid_o & out_stall_i;
  assign in_stall_o = in_valid_q & out_busy;
  assign advance    = in_valid_q & ~out_busy;

  always_comb begin
    dec = '0;
    if (advance) begin
      case (req_q)
        lmks_pkg::REQ_TICK:      dec.tick    = 1'b1;
        lmks_pkg::REQ_WRITE_PIX: dec.wr_pix  = 1'b1;
        lmks_pkg::REQ_READ_PIX:  dec.rd_pix  = 1'b1;
        lmks_pkg::REQ_POP_EVENT: dec.pop     = 1'b1;
        lmks_pkg::REQ_READ_HOLD: dec.rd_hold = 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    scan_d = scan_q;
    tick_d = tick_q;
    if (dec.tick) begin
      tick_d = tick_q + 1'b1;
      scan_d = (scan_q == CW'(COLS - 1)) ? '0 : scan_q + 1'b1;
    end
  end

  lmks_frame #(
    .ROWS (ROWS),
    .COLS (COLS),
    .CW   (CW)
  ) u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dec_i       (dec),
    .row_i       (row_q),
    .column_i    (col_q),
    .pixel_in_i  (pix_q),
    .scan_col_i  (scan_d),
    .pixel_out_o (pix_rd),
    .row_drive_o (drive)
  );

  lmks_keys #(
    .KEYS (KEYS)
  ) u_keys (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .dec_i          (dec),
    .button_i       (btn_q),
    .keys_pressed_i (keys_q),
    .tick_i         (tick_d),
    .first_delay_i  (first_delay_q),
    .rearm_i        (rearm_q),
    .hold_limit_i   (hold_limit_q),
    .event_taken_o  (taken),
    .hold_level_o   (level)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_delay_q <= lmks_pkg::FIRST_DELAY_RST;
      rearm_q       <= lmks_pkg::REARM_RST;
      hold_limit_q  <= lmks_pkg::HOLD_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (lmks_pkg::cfg_idx_e'(cfg_idx_i))
        lmks_pkg::CFG_FIRST_DELAY: first_delay_q <= cfg_data_i;
        lmks_pkg::CFG_REARM_BACK:  rearm_q       <= cfg_data_i;
        lmks_pkg::CFG_HOLD_LIMIT:  hold_limit_q  <= cfg_data_i[lmks_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      req_q  <= lmks_pkg::req_e'(req_type_i);
      row_q  <= row_i;
      col_q  <= column_i;
      pix_q  <= pixel_in_i;
      btn_q  <= button_i;
      keys_q <= keys_pressed_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
      tick_q <= '0;
    end else begin
      scan_q <= scan_d;
      tick_q <= tick_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (advance) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      row_drive_o     <= drive;
      active_column_o <= lmks_pkg::COL_W'(scan_d);
      pixel_out_o     <= pix_rd;
      event_taken_o   <= taken;
      hold_level_o    <= level;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lmks_frame.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmks_frame
// one-bit frame store with pixel write and read and the row drive of the
// active column
// ----------------------------------------------------------------------------
module lmks_frame #(
  parameter int unsigned ROWS = 16,
  parameter int unsigned COLS = 8,
  parameter int unsigned CW   = 3
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  lmks_pkg::req_dec_t                dec_i,
  input  wire  [lmks_pkg::ROW_W-1:0]        row_i,
  input  wire  [lmks_pkg::COL_W-1:0]        column_i,
  input  wire                               pixel_in_i,
  input  wire  [CW-1:0]                     scan_col_i,
  output logic                              pixel_out_o,
  output logic [lmks_pkg::DRIVE_W-1:0]      row_drive_o
);

  logic [COLS-1:0] frame_q [ROWS];
  logic [COLS-1:0] frame_d [ROWS];
  logic [COLS-1:0] col_sel;
  logic [COLS-1:0] scan_sel;
  logic [ROWS-1:0] row_sel;
  logic            pix;

  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      col_sel[c]  = (int'(column_i) == c);
      scan_sel[c] = (int'(scan_col_i) == c);
    end
    for (int r = 0; r < ROWS; r++) begin
      row_sel[r] = (int'(row_i) == r);
    end
  end

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        frame_d[r][c] = (dec_i.wr_pix && row_sel[r] && col_sel[c]) ? pixel_in_i
                                                                   : frame_q[r][c];
      end
    end
  end

  always_comb begin
    pix = 1'b0;
    for (int r = 0; r < ROWS; r++) begin
      pix = pix | (row_sel[r] & (|(frame_q[r] & col_sel)));
    end
    pixel_out_o = dec_i.rd_pix & pix;
  end

  // drive reflects the store after this request
  always_comb begin
    row_drive_o = '0;
    for (int r = 0; r < ROWS && r < lmks_pkg::DRIVE_W; r++) begin
      row_drive_o[r] = |(frame_d[r] & scan_sel);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        frame_q[r] <= '0;
      end
    end else begin
      for (int r = 0; r < ROWS; r++) begin
        frame_q[r] <= frame_d[r];
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lmks_keys.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmks_keys
// per-key hold level, auto-repeat timestamp and saturating event count
// ----------------------------------------------------------------------------
module lmks_keys #(
  parameter int unsigned KEYS = 6
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  lmks_pkg::req_dec_t                dec_i,
  input  wire  [lmks_pkg::BTN_W-1:0]        button_i,
  input  wire  [lmks_pkg::KEY_BITS-1:0]     keys_pressed_i,
  input  wire  [lmks_pkg::TS_W-1:0]         tick_i,
  input  wire  [lmks_pkg::TS_W-1:0]         first_delay_i,
  input  wire  [lmks_pkg::TS_W-1:0]         rearm_i,
  input  wire  [lmks_pkg::LEVEL_W-1:0]      hold_limit_i,
  output logic                              event_taken_o,
  output logic [lmks_pkg::LEVEL_W-1:0]      hold_level_o
);

  logic [KEYS-1:0]                        taken_v;
  logic [KEYS-1:0][lmks_pkg::LEVEL_W-1:0] level_v;

  for (genvar gk = 0; gk < KEYS; gk++) begin : g_key
    logic                         down;
    logic                         sel;
    logic                         queue;
    logic [lmks_pkg::TS_W-1:0]    elapsed;
    logic [lmks_pkg::LEVEL_W-1:0] hold_q, hold_d;
    logic [lmks_pkg::CNT_W-1:0]   cnt_q, cnt_d;
    logic [lmks_pkg::TS_W-1:0]    ts_q, ts_d;

    if (gk < lmks_pkg::KEY_BITS) begin : g_pin
      assign down = keys_pressed_i[gk];
    end else begin : g_nopin
      assign down = 1'b0;
    end

    assign sel     = (int'(button_i) == gk);
    assign elapsed = tick_i - ts_q;

    always_comb begin
      hold_d = hold_q;
      cnt_d  = cnt_q;
      ts_d   = ts_q;
      queue  = 1'b0;
      if (dec_i.tick) begin
        if (down) begin
          if (hold_q == '0) begin
            queue = 1'b1;
            ts_d  = tick_i;
          end else if (elapsed > first_delay_i) begin
            queue = 1'b1;
            ts_d  = tick_i - rearm_i;
          end
          if (hold_q < hold_limit_i) begin
            hold_d = hold_q + 1'b1;
          end
        end else if (hold_q != '0) begin
          hold_d = hold_q - 1'b1;
        end
        if (queue && cnt_q != lmks_pkg::CNT_MAX) begin
          cnt_d = cnt_q + 1'b1;
        end
      end else if (dec_i.pop && sel && cnt_q != '0) begin
        cnt_d = cnt_q - 1'b1;
      end
    end

    assign taken_v[gk] = dec_i.pop & sel & (cnt_q != '0);
    assign level_v[gk] = (dec_i.rd_hold && sel) ? hold_q : '0;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        hold_q <= '0;
        cnt_q  <= '0;
        ts_q   <= '0;
      end else begin
        hold_q <= hold_d;
        cnt_q  <= cnt_d;
        ts_q   <= ts_d;
      end
    end
  end

  always_comb begin
    event_taken_o = |taken_v;
    hold_level_o  = '0;
    for (int k = 0; k < KEYS; k++) begin
      hold_level_o = hold_level_o | level_v[k];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lmks_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmks_checker
// port-level checks on the scanner's transfers and results
// ----------------------------------------------------------------------------
module lmks_checker (
  input wire                             clk_i,
  input wire                             rst_ni,
  input wire                             in_valid_i,
  input wire                             in_stall_o,
  input wire                             out_valid_o,
  input wire                             out_stall_i,
  input wire [lmks_pkg::DRIVE_W-1:0]     row_drive_o,
  input wire                             pixel_out_o,
  input wire                             event_taken_o,
  input wire [lmks_pkg::LEVEL_W-1:0]     hold_level_o
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(row_drive_o))
    else $error("stalled result changed");

  // input side only stalls behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // a fresh result needs a transfer in that passed through the input register
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a matching transfer");

  // only one request kind fills a result field
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_taken_o |-> !pixel_out_o && hold_level_o == '0)
    else $error("result fields from more than one request kind");

endmodule

bind led_matrix_and_keypad_scanner lmks_checker u_lmks_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .row_drive_o   (row_drive_o),
  .pixel_out_o   (pixel_out_o),
  .event_taken_o (event_taken_o),
  .hold_level_o  (hold_level_o)
);
`default_nettype wire
